// ----- sv/rotation_matrix_to_quaternion_macros.svh -----
// Assertion macros for the rotation matrix to quaternion block.
// Used by the checker file; expects clk and rst_n in the including scope.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define RMQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmq check failed: same-cycle property");

// Consequent must hold in the cycle after the antecedent
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmq check failed: next-cycle property");

`endif

// ----- sv/rmq_pkg.sv -----
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies; used by the channel interfaces, the top level and the checker.
package rmq_pkg;

  localparam int DW       = 16;         // field width
  localparam int FB       = 14;         // fraction bits
  localparam int S_W      = 16;         // square root width
  localparam int N_W      = 2 * S_W;    // radicand width
  localparam int REM_W    = 18;         // root remainder width
  localparam int ARG_W    = 17;         // positive root argument width
  localparam int D_W      = 17;         // sum / difference width
  localparam int NUM_W    = 31;         // dividend width
  localparam int Q_BITS   = 23;         // quotient bits
  localparam int SQ_STEPS = S_W;        // root stages, one result bit each
  // matrix, argument, root, divider setup, divider and output registers
  localparam int NST      = SQ_STEPS + Q_BITS + 4;

  localparam logic [2:0] ADDR_AXES = 3'd0;

  typedef logic signed [DW-1:0]  sample_t;
  typedef logic signed [D_W-1:0] diff_t;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  // Root stage payload
  typedef struct packed {
    logic [N_W-1:0]   n;
    logic [S_W-1:0]   root;
    logic [REM_W-1:0] rem;
    diff_t            d0;
    diff_t            d1;
    diff_t            d2;
    branch_t          br;
    logic             degen;
  } sq_t;

  // Divide stage payload, three lanes share one divisor
  typedef struct packed {
    logic [2:0][NUM_W-1:0]  rem;
    logic [2:0][Q_BITS-1:0] quo;
    logic [2:0]             neg;
    logic [S_W:0]           den;
    logic [S_W-1:0]         half;
    branch_t                br;
    logic                   degen;
  } dv_t;

endpackage

// ----- sv/rmq_in_if.sv -----
// Input channel: one 3x3 matrix per transaction.
// Depends on rmq_pkg.
interface rmq_in_if;
  import rmq_pkg::*;
  logic    valid;
  logic    ready;
  sample_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

// ----- sv/rmq_out_if.sv -----
// Result channel: one quaternion with branch and degenerate flags per transaction.
// Depends on rmq_pkg.
interface rmq_out_if;
  import rmq_pkg::*;
  logic    valid;
  logic    ready;
  sample_t qw, qx, qy, qz;
  branch_t branch_taken;
  logic    degenerate;
  modport source (output valid, qw, qx, qy, qz, branch_taken, degenerate,
                  input ready);
  modport sink (input valid, qw, qx, qy, qz, branch_taken, degenerate,
                output ready);
endinterface

// ----- sv/rotation_matrix_to_quaternion.sv -----
// Rotation matrix to unit quaternion, fully pipelined.
// Depends on rmq_pkg, rmq_in_if and rmq_out_if.
//
// Usage:
//   in_ch carries one 3x3 matrix of signed Q2.14 entries per transaction;
//   out_ch returns qw, qx, qy, qz (Q2.14, saturated), branch_taken and
//   degenerate for it, in the same order as the inputs.
//   The APB port holds one register at address 0: bit 0 is input_is_axes,
//   which transposes the matrix before use. Write it only while idle.
// Timing:
//   Throughput is one matrix per cycle unless out_ch stalls the pipeline.
//   The depth comes from the 16-stage square root (one root bit per stage)
//   and the 23-stage divider (one quotient bit per stage, three lanes
//   sharing the divisor).
// Reset and stall:
//   rst_n low clears input_is_axes and all stage valid bits.
//   When the receiver holds out_ch.ready low with a result pending, the
//   whole pipeline freezes and in_ch.ready drops; nothing is lost or doubled.
module rotation_matrix_to_quaternion (
  input  logic        clk,
  input  logic        rst_n,
  rmq_in_if.sink      in_ch,
  rmq_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rmq_pkg::*;

  localparam logic signed [ARG_W+1:0] ONE_V = (ARG_W+2)'(2**FB);

  logic             axes_r;
  logic             en;
  logic [NST-1:0]   vld_r;

  sample_t          in_m [3][3];
  sample_t          mt_r [3][3];
  logic signed [DW+1:0] tr_r;

  sq_t              sq_r [SQ_STEPS+1];
  sq_t              sq0_nxt;
  dv_t              dv_r [Q_BITS+1];
  dv_t              dv0_nxt;

  sample_t          qw_r, qx_r, qy_r, qz_r;
  branch_t          br_r;
  logic             degen_r;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_AXES) ? {31'b0, axes_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axes_r <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == ADDR_AXES)) begin
      axes_r <= pwdata[0];
    end
  end

  // Global advance: freeze everything while a result waits
  assign en          = !vld_r[NST-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

  // Stage 1: capture matrix in rotation convention and the trace
  always_comb begin
    in_m[0][0] = in_ch.m00; in_m[0][1] = in_ch.m01; in_m[0][2] = in_ch.m02;
    in_m[1][0] = in_ch.m10; in_m[1][1] = in_ch.m11; in_m[1][2] = in_ch.m12;
    in_m[2][0] = in_ch.m20; in_m[2][1] = in_ch.m21; in_m[2][2] = in_ch.m22;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mt_r[r][c] <= axes_r ? in_m[c][r] : in_m[r][c];
        end
      end
      tr_r <= (DW+2)'(in_ch.m00) + (DW+2)'(in_ch.m11) + (DW+2)'(in_ch.m22);
    end
  end

  // Stage 2: pick branch, form root argument and the three sums / differences
  always_comb begin
    logic signed [ARG_W+1:0] arg;
    logic [1:0]              idx;
    sq0_nxt = '0;
    idx     = 2'd0;
    if (mt_r[1][1] > mt_r[0][0]) begin
      idx = 2'd1;
    end
    if (mt_r[2][2] > ((idx == 2'd1) ? mt_r[1][1] : mt_r[0][0])) begin
      idx = 2'd2;
    end
    if (tr_r > 0) begin
      arg        = (ARG_W+2)'(tr_r) + ONE_V;
      sq0_nxt.br = BR_TRACE;
      sq0_nxt.d0 = D_W'(mt_r[2][1]) - D_W'(mt_r[1][2]);
      sq0_nxt.d1 = D_W'(mt_r[0][2]) - D_W'(mt_r[2][0]);
      sq0_nxt.d2 = D_W'(mt_r[1][0]) - D_W'(mt_r[0][1]);
    end else begin
      case (idx)
        2'd0: begin
          arg = (ARG_W+2)'(mt_r[0][0]) - (ARG_W+2)'(mt_r[1][1])
                - (ARG_W+2)'(mt_r[2][2]) + ONE_V;
          sq0_nxt.br = BR_X;
          sq0_nxt.d0 = D_W'(mt_r[2][1]) - D_W'(mt_r[1][2]);
          sq0_nxt.d1 = D_W'(mt_r[1][0]) + D_W'(mt_r[0][1]);
          sq0_nxt.d2 = D_W'(mt_r[2][0]) + D_W'(mt_r[0][2]);
        end
        2'd1: begin
          arg = (ARG_W+2)'(mt_r[1][1]) - (ARG_W+2)'(mt_r[2][2])
                - (ARG_W+2)'(mt_r[0][0]) + ONE_V;
          sq0_nxt.br = BR_Y;
          sq0_nxt.d0 = D_W'(mt_r[0][2]) - D_W'(mt_r[2][0]);
          sq0_nxt.d1 = D_W'(mt_r[0][1]) + D_W'(mt_r[1][0]);
          sq0_nxt.d2 = D_W'(mt_r[2][1]) + D_W'(mt_r[1][2]);
        end
        default: begin
          arg = (ARG_W+2)'(mt_r[2][2]) - (ARG_W+2)'(mt_r[0][0])
                - (ARG_W+2)'(mt_r[1][1]) + ONE_V;
          sq0_nxt.br = BR_Z;
          sq0_nxt.d0 = D_W'(mt_r[1][0]) - D_W'(mt_r[0][1]);
          sq0_nxt.d1 = D_W'(mt_r[0][2]) + D_W'(mt_r[2][0]);
          sq0_nxt.d2 = D_W'(mt_r[1][2]) + D_W'(mt_r[2][1]);
        end
      endcase
      // floor a non-positive argument at one LSB
      if (arg <= 0) begin
        arg           = (ARG_W+2)'(1);
        sq0_nxt.degen = 1'b1;
      end
    end
    sq0_nxt.n = {1'b0, arg[ARG_W-1:0], {FB{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= sq0_nxt;
    end
  end

  // Square root: one root bit per stage, restoring
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    sq_t              nxt;
    always_comb begin
      nxt   = sq_r[g];
      cur   = {sq_r[g].rem, sq_r[g].n[N_W-1 -: 2]};
      trial = {(REM_W-S_W)'(0), sq_r[g].root, 2'b01};
      if (cur >= trial) begin
        nxt.rem  = REM_W'(cur - trial);
        nxt.root = {sq_r[g].root[S_W-2:0], 1'b1};
      end else begin
        nxt.rem  = REM_W'(cur);
        nxt.root = {sq_r[g].root[S_W-2:0], 1'b0};
      end
      nxt.n = {sq_r[g].n[N_W-3:0], 2'b00};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[g+1] <= nxt;
      end
    end
  end

  // Dividend for one lane: |d| * 2^FB plus s for round-half-up on d/(2s)
  function automatic logic [NUM_W-1:0] num_of(diff_t d, logic [S_W-1:0] s);
    logic signed [D_W:0] dx;
    logic [D_W-1:0]      mag;
    dx  = (D_W+1)'(d);
    mag = D_W'((dx < 0) ? -dx : dx);
    return NUM_W'({mag, {FB{1'b0}}}) + NUM_W'(s);
  endfunction

  // Divider setup from the finished root
  always_comb begin
    logic [S_W-1:0] s;
    s              = sq_r[SQ_STEPS].root;
    dv0_nxt        = '0;
    dv0_nxt.den    = {s, 1'b0};
    dv0_nxt.half   = S_W'(((S_W+1)'(s) + (S_W+1)'(1)) >> 1);
    dv0_nxt.br     = sq_r[SQ_STEPS].br;
    dv0_nxt.degen  = sq_r[SQ_STEPS].degen;
    dv0_nxt.rem[0] = num_of(sq_r[SQ_STEPS].d0, s);
    dv0_nxt.rem[1] = num_of(sq_r[SQ_STEPS].d1, s);
    dv0_nxt.rem[2] = num_of(sq_r[SQ_STEPS].d2, s);
    dv0_nxt.neg[0] = sq_r[SQ_STEPS].d0 < 0;
    dv0_nxt.neg[1] = sq_r[SQ_STEPS].d1 < 0;
    dv0_nxt.neg[2] = sq_r[SQ_STEPS].d2 < 0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  // Divider: one quotient bit per stage, most significant first
  for (genvar g = 0; g < Q_BITS; g++) begin : g_div
    localparam int B = Q_BITS - 1 - g;
    logic [NUM_W+Q_BITS-1:0] dsh;
    dv_t                     nxt;
    always_comb begin
      nxt = dv_r[g];
      dsh = (NUM_W+Q_BITS)'(dv_r[g].den) << B;
      for (int j = 0; j < 3; j++) begin
        if ((NUM_W+Q_BITS)'(dv_r[g].rem[j]) >= dsh) begin
          nxt.rem[j]    = NUM_W'((NUM_W+Q_BITS)'(dv_r[g].rem[j]) - dsh);
          nxt.quo[j][B] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[g+1] <= nxt;
      end
    end
  end

  // Apply sign and clamp to the field range
  function automatic sample_t sat_q(logic [Q_BITS-1:0] q, logic neg);
    logic signed [Q_BITS+1:0] v;
    v = $signed({2'b00, q});
    if (neg) begin
      v = -v;
    end
    if (v > (Q_BITS+2)'(2**(DW-1) - 1)) begin
      return {1'b0, {(DW-1){1'b1}}};
    end else if (v < -(Q_BITS+2)'(2**(DW-1))) begin
      return {1'b1, {(DW-1){1'b0}}};
    end
    return DW'(v);
  endfunction

  // Output register: place the root part by branch
  always_ff @(posedge clk) begin
    sample_t r0, r1, r2, h;
    if (en) begin
      r0 = sat_q(dv_r[Q_BITS].quo[0], dv_r[Q_BITS].neg[0]);
      r1 = sat_q(dv_r[Q_BITS].quo[1], dv_r[Q_BITS].neg[1]);
      r2 = sat_q(dv_r[Q_BITS].quo[2], dv_r[Q_BITS].neg[2]);
      h  = dv_r[Q_BITS].half;
      case (dv_r[Q_BITS].br)
        BR_TRACE: begin qw_r <= h;  qx_r <= r0; qy_r <= r1; qz_r <= r2; end
        BR_X:     begin qw_r <= r0; qx_r <= h;  qy_r <= r1; qz_r <= r2; end
        BR_Y:     begin qw_r <= r0; qx_r <= r1; qy_r <= h;  qz_r <= r2; end
        default:  begin qw_r <= r0; qx_r <= r1; qy_r <= r2; qz_r <= h;  end
      endcase
      br_r    <= dv_r[Q_BITS].br;
      degen_r <= dv_r[Q_BITS].degen;
    end
  end

  assign out_ch.valid        = vld_r[NST-1];
  assign out_ch.qw           = qw_r;
  assign out_ch.qx           = qx_r;
  assign out_ch.qy           = qy_r;
  assign out_ch.qz           = qz_r;
  assign out_ch.branch_taken = br_r;
  assign out_ch.degenerate   = degen_r;

endmodule

// ----- sv/rmq_checker.sv -----
// Port-level checks for the rotation matrix to quaternion block, with its bind.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_macros.svh.
`include "rotation_matrix_to_quaternion_macros.svh"

module rmq_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input rmq_pkg::sample_t qw,
  input rmq_pkg::sample_t qx,
  input rmq_pkg::sample_t qy,
  input rmq_pkg::sample_t qz,
  input rmq_pkg::branch_t branch_taken,
  input logic             degenerate
);
  import rmq_pkg::*;

  logic [4*DW+2:0] res_all;
  logic            root_ok;

  assign res_all = {qw, qx, qy, qz, branch_taken, degenerate};

  // Select the sign bit of the part taken from the root
  always_comb begin
    case (branch_taken)
      BR_TRACE: root_ok = !qw[DW-1];
      BR_X:     root_ok = !qx[DW-1];
      BR_Y:     root_ok = !qy[DW-1];
      default:  root_ok = !qz[DW-1];
    endcase
  end

  // Hold a stalled result
  `RMQ_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid)
  `RMQ_ASSERT_NEXT(a_hold_data, out_valid && !out_ready, $stable(res_all))

  // Floored root only happens off the positive-trace path
  `RMQ_ASSERT_SAME(a_degen_branch, out_valid && degenerate, branch_taken != BR_TRACE)

  // The part taken from the root is never negative
  `RMQ_ASSERT_SAME(a_root_sign, out_valid, root_ok)

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .qw           (out_ch.qw),
  .qx           (out_ch.qx),
  .qy           (out_ch.qy),
  .qz           (out_ch.qz),
  .branch_taken (out_ch.branch_taken),
  .degenerate   (out_ch.degenerate)
);
